FILE: rtl/core/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/spira_pkg.sv
// types and constants shared by the spi register access master
`timescale 1ns / 1ps

package spira_pkg;

    // input item kinds carried on tuser
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // reset value of the device address register
    localparam logic [6:0] CHIP_ADDR_RESET = 7'd4;

    // index of the last byte of the three byte frame
    localparam logic [1:0] FRAME_LAST_BYTE = 2'd2;

    // widths of the packed stream words
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    // one input item
    typedef struct packed {
        logic       kind;
        logic       read_not_write;
        logic [7:0] reg_address;
        logic [7:0] write_data;
        logic       serial_data_in;
    } item_t;

    // one result item
    typedef struct packed {
        logic       chip_select;
        logic       serial_clock;
        logic       serial_data_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       start_ignored;
    } result_t;

endpackage

FILE: rtl/core/spi_register_access_master.sv
// top level of the tick driven spi register access master
//
// channel  | dir | handshake                    | content
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | start or tick transaction
// m_axis   | out | m_axis_tvalid/m_axis_tready  | line levels and status per item
// cfg      | in  | cfg_we                       | device address register
//
// one transaction per cycle while m_axis is not stalled; a result is offered on m_axis
// after its input passes the input register, then the sequencer into the output register
// reset clears the handshake flags and the sequencer, and sets the address register to 4
// a stall on m_axis holds the result; s_axis_tready drops only while both
// registers are full and m_axis_tready is low
`timescale 1ns / 1ps

module spi_register_access_master (
    input  logic                             aclk,
    input  logic                             aresetn,
    // device address, written while idle
    input  logic                             cfg_we,
    input  logic [6:0]                       cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // read_not_write[0], reg_address[8:1], write_data[16:9], serial_data_in[17], zero pad
    input  logic [spira_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // kind[0]
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // chip_select[0], serial_clock[1], serial_data_out[2], busy_res[3], done_res[4],
    // read_data[12:5], start_ignored[13], zero pad
    output logic [spira_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    spira_pkg::item_t   s_item;
    spira_pkg::item_t   item;
    spira_pkg::result_t result;
    logic               item_valid;
    logic               out_ready;
    logic               fire;
    logic               m_valid_reg;
    logic               m_valid_next;
    spira_pkg::result_t m_result_reg;

    // unpack the input transaction
    always_comb begin
        s_item.kind           = s_axis_tuser;
        s_item.read_not_write = s_axis_tdata[0];
        s_item.reg_address    = s_axis_tdata[8:1];
        s_item.write_data     = s_axis_tdata[16:9];
        s_item.serial_data_in = s_axis_tdata[17];
    end

    // output register free or being emptied
    assign out_ready = !m_valid_reg || m_axis_tready;
    assign fire      = item_valid && out_ready;

    spira_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (s_item),
        .down_ready (out_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    spira_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (item),
        .result    (result)
    );

    // output register valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_ready) begin
            m_valid_next = item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_result_reg <= result;
        end
    end

    // pack the result transaction
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00,
                            m_result_reg.start_ignored,
                            m_result_reg.read_data,
                            m_result_reg.done_res,
                            m_result_reg.busy_res,
                            m_result_reg.serial_data_out,
                            m_result_reg.serial_clock,
                            m_result_reg.chip_select};

endmodule

FILE: rtl/core/spira_in_reg.sv
// input register stage holding one accepted transaction
`timescale 1ns / 1ps

module spira_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  spira_pkg::item_t in_item,
    input  logic            down_ready,
    output logic            item_valid,
    output spira_pkg::item_t item
);

    logic             valid_reg;
    logic             valid_next;
    spira_pkg::item_t item_reg;

    // take a new transaction when empty or when the held one moves on
    assign in_ready   = !valid_reg || down_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // valid flag follows the handshake on both sides
    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

endmodule

FILE: rtl/core/spira_seq.sv
// frame sequencer: line levels, counters, capture and device address register
`timescale 1ns / 1ps

module spira_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_wdata,
    input  logic               fire,
    input  spira_pkg::item_t   item,
    output spira_pkg::result_t result
);

    // sequence phases
    localparam logic [2:0] PH_SEL_HIGH = 3'd0;
    localparam logic [2:0] PH_SEL_LOW  = 3'd1;
    localparam logic [2:0] PH_DRIVE    = 3'd2;
    localparam logic [2:0] PH_CLK_HIGH = 3'd3;
    localparam logic [2:0] PH_BIT_INC  = 3'd4;
    localparam logic [2:0] PH_CLK_LOW  = 3'd5;
    localparam logic [2:0] PH_FINISH   = 3'd6;

    logic [6:0]  chip_addr_reg;
    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [1:0]  byte_index_reg, byte_index_next;
    logic [23:0] frame_reg, frame_next;
    logic [7:0]  captured_reg, captured_next;
    logic        active_reg, active_next;
    logic        sel_reg, sel_next;
    logic        clk_reg, clk_next;
    logic        dat_reg, dat_next;

    logic        done;
    logic        ignored;
    logic [2:0]  pos;
    logic [7:0]  cur_byte;

    // bit position, msb first
    assign pos = 3'd7 - bit_index_reg[2:0];

    // frame byte selected by the byte counter
    always_comb begin
        unique case (byte_index_reg)
            2'd0:    cur_byte = frame_reg[23:16];
            2'd1:    cur_byte = frame_reg[15:8];
            2'd2:    cur_byte = frame_reg[7:0];
            default: cur_byte = 8'd0;
        endcase
    end

    // next state for one transaction
    always_comb begin
        phase_next      = phase_reg;
        bit_index_next  = bit_index_reg;
        byte_index_next = byte_index_reg;
        frame_next      = frame_reg;
        captured_next   = captured_reg;
        active_next     = active_reg;
        sel_next        = sel_reg;
        clk_next        = clk_reg;
        dat_next        = dat_reg;
        done            = 1'b0;
        ignored         = 1'b0;
        if (fire) begin
            if (item.kind == spira_pkg::KIND_START) begin
                if (active_reg) begin
                    ignored = 1'b1;
                end else begin
                    frame_next = {chip_addr_reg, item.read_not_write, item.reg_address,
                                  item.read_not_write ? 8'd0 : item.write_data};
                    captured_next   = 8'd0;
                    sel_next        = 1'b1;
                    clk_next        = 1'b0;
                    dat_next        = 1'b0;
                    phase_next      = PH_SEL_HIGH;
                    bit_index_next  = 4'd0;
                    byte_index_next = 2'd0;
                    active_next     = 1'b1;
                end
            end else if (active_reg) begin
                unique case (phase_reg)
                    PH_SEL_HIGH: begin
                        sel_next        = 1'b1;
                        captured_next   = 8'd0;
                        bit_index_next  = 4'd0;
                        byte_index_next = 2'd0;
                        phase_next      = PH_SEL_LOW;
                    end
                    PH_SEL_LOW: begin
                        sel_next   = 1'b0;
                        phase_next = PH_DRIVE;
                    end
                    PH_DRIVE: begin
                        dat_next = cur_byte[pos];
                        if (byte_index_reg == 2'd2) begin
                            captured_next = captured_reg | (8'(item.serial_data_in) << pos);
                        end
                        phase_next = PH_CLK_HIGH;
                    end
                    PH_CLK_HIGH: begin
                        clk_next   = 1'b1;
                        phase_next = PH_BIT_INC;
                    end
                    PH_BIT_INC: begin
                        bit_index_next = bit_index_reg + 4'd1;
                        phase_next     = PH_CLK_LOW;
                    end
                    PH_CLK_LOW: begin
                        clk_next = 1'b0;
                        if (bit_index_reg < 4'd8) begin
                            phase_next = PH_DRIVE;
                        end else if (byte_index_reg < spira_pkg::FRAME_LAST_BYTE) begin
                            byte_index_next = byte_index_reg + 2'd1;
                            bit_index_next  = 4'd0;
                            phase_next      = PH_DRIVE;
                        end else begin
                            phase_next = PH_FINISH;
                        end
                    end
                    // end of frame, also the unused phase
                    default: begin
                        sel_next    = 1'b1;
                        active_next = 1'b0;
                        phase_next  = PH_SEL_HIGH;
                        done        = 1'b1;
                    end
                endcase
            end
        end
    end

    // result shows the levels after the transaction
    always_comb begin
        result.chip_select     = sel_next;
        result.serial_clock    = clk_next;
        result.serial_data_out = dat_next;
        result.busy_res        = active_next;
        result.done_res        = done;
        result.read_data       = captured_next;
        result.start_ignored   = ignored;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chip_addr_reg  <= spira_pkg::CHIP_ADDR_RESET;
            phase_reg      <= PH_SEL_HIGH;
            bit_index_reg  <= 4'd0;
            byte_index_reg <= 2'd0;
            frame_reg      <= 24'd0;
            captured_reg   <= 8'd0;
            active_reg     <= 1'b0;
            sel_reg        <= 1'b1;
            clk_reg        <= 1'b0;
            dat_reg        <= 1'b0;
        end else begin
            if (cfg_we) begin
                chip_addr_reg <= cfg_wdata;
            end
            phase_reg      <= phase_next;
            bit_index_reg  <= bit_index_next;
            byte_index_reg <= byte_index_next;
            frame_reg      <= frame_next;
            captured_reg   <= captured_next;
            active_reg     <= active_next;
            sel_reg        <= sel_next;
            clk_reg        <= clk_next;
            dat_reg        <= dat_next;
        end
    end

endmodule

FILE: rtl/core/spira_checker.sv
// port level checks of the spi register access master and their bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spira_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [spira_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    logic                            vld;
    logic                            stall;
    logic                            cs;
    logic                            sclk;
    logic                            busy;
    logic                            done;
    logic                            dropped;
    logic [spira_pkg::M_TDATA_W-1:0] word;

    // result fields as seen on the port
    assign vld     = m_axis_tvalid;
    assign stall   = m_axis_tvalid && !m_axis_tready;
    assign word    = m_axis_tdata;
    assign cs      = m_axis_tdata[0];
    assign sclk    = m_axis_tdata[1];
    assign busy    = m_axis_tdata[3];
    assign done    = m_axis_tdata[4];
    assign dropped = m_axis_tdata[13];

    // nothing is offered right after reset
    `ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !vld, "result valid after reset")

    // a stalled result holds
    `ASSERT_CLKD(a_stall_hold, aclk, aresetn, stall |=> vld && $stable(word), "result changed")

    // the frame end leaves the block idle
    `ASSERT_CLKD(a_done_idle, aclk, aresetn, vld && done |-> !busy, "done while busy")

    // a dropped start only happens during a frame
    `ASSERT_CLKD(a_ignored_busy, aclk, aresetn, vld && dropped |-> busy && !done, "idle drop")

    // idle lines: select high, clock low
    `ASSERT_CLKD(a_idle_lines, aclk, aresetn, vld && !busy |-> cs && !sclk, "idle lines wrong")

endmodule

bind spi_register_access_master spira_checker u_spira_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: dv/spi_register_access_master_tb.sv
// self-checking testbench for the spi register access master
`timescale 1ns / 1ps

module spi_register_access_master_tb;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int BUSY_START_PCT = 5;

    // sequencer phases of one frame
    typedef enum logic [2:0] {
        PH_RAISE_CS, PH_DROP_CS, PH_DRIVE, PH_CLK_HIGH,
        PH_COUNT, PH_CLK_LOW, PH_FINISH, PH_SPARE
    } seq_phase_t;

    // tracks the spi line levels and holds the levels still to come out
    class spi_scoreboard_t;
        logic [6:0]                    chip_addr;
        seq_phase_t                    phase;
        logic [3:0]                    bit_idx;
        logic [1:0]                    byte_idx;
        logic [23:0]                   frame;
        logic [7:0]                    captured;
        logic                          active;
        logic                          cs;
        logic                          sclk;
        logic                          sdo;
        spira_pkg::result_t            expected_levels[$];
        int                            mismatches;

        function new();
            chip_addr  = spira_pkg::CHIP_ADDR_RESET;
            phase      = PH_RAISE_CS;
            bit_idx    = '0;
            byte_idx   = '0;
            frame      = '0;
            captured   = '0;
            active     = 1'b0;
            cs         = 1'b1;
            sclk       = 1'b0;
            sdo        = 1'b0;
            mismatches = 0;
        endfunction

        // advance the line model by one accepted transaction
        function void note_item(spira_pkg::item_t it);
            spira_pkg::result_t r;
            logic [7:0]         cur;
            int                 pos;
            r.done_res      = 1'b0;
            r.start_ignored = 1'b0;
            if (it.kind == spira_pkg::KIND_START) begin
                if (active) begin
                    r.start_ignored = 1'b1;
                end else begin
                    frame    = {chip_addr, it.read_not_write, it.reg_address,
                                it.read_not_write ? 8'h00 : it.write_data};
                    captured = '0;
                    cs       = 1'b1;
                    sclk     = 1'b0;
                    sdo      = 1'b0;
                    phase    = PH_RAISE_CS;
                    bit_idx  = '0;
                    byte_idx = '0;
                    active   = 1'b1;
                end
            end else if (active) begin
                case (phase)
                    PH_RAISE_CS: begin
                        cs       = 1'b1;
                        captured = '0;
                        bit_idx  = '0;
                        byte_idx = '0;
                        phase    = PH_DROP_CS;
                    end
                    PH_DROP_CS: begin
                        cs    = 1'b0;
                        phase = PH_DRIVE;
                    end
                    PH_DRIVE: begin
                        pos = 7 - int'(bit_idx[2:0]);
                        case (byte_idx)
                            2'd0:    cur = frame[23:16];
                            2'd1:    cur = frame[15:8];
                            2'd2:    cur = frame[7:0];
                            default: cur = 8'h00;
                        endcase
                        sdo = cur[pos];
                        // the device answers during the last byte
                        if (byte_idx == spira_pkg::FRAME_LAST_BYTE)
                            captured[pos] = captured[pos] | it.serial_data_in;
                        phase = PH_CLK_HIGH;
                    end
                    PH_CLK_HIGH: begin
                        sclk  = 1'b1;
                        phase = PH_COUNT;
                    end
                    PH_COUNT: begin
                        bit_idx = bit_idx + 4'd1;
                        phase   = PH_CLK_LOW;
                    end
                    PH_CLK_LOW: begin
                        sclk = 1'b0;
                        if (bit_idx < 4'd8) begin
                            phase = PH_DRIVE;
                        end else if (byte_idx < spira_pkg::FRAME_LAST_BYTE) begin
                            byte_idx = byte_idx + 2'd1;
                            bit_idx  = '0;
                            phase    = PH_DRIVE;
                        end else begin
                            phase = PH_FINISH;
                        end
                    end
                    default: begin
                        cs         = 1'b1;
                        active     = 1'b0;
                        phase      = PH_RAISE_CS;
                        r.done_res = 1'b1;
                    end
                endcase
            end
            r.chip_select     = cs;
            r.serial_clock    = sclk;
            r.serial_data_out = sdo;
            r.busy_res        = active;
            r.read_data       = captured;
            expected_levels.push_back(r);
        endfunction

        // expected levels in the port layout
        function logic [spira_pkg::M_TDATA_W-1:0] pack_levels(spira_pkg::result_t r);
            return {2'b00, r.start_ignored, r.read_data, r.done_res, r.busy_res,
                    r.serial_data_out, r.serial_clock, r.chip_select};
        endfunction

        // compare one result transaction with the oldest expectation
        function void check_levels(logic [spira_pkg::M_TDATA_W-1:0] word);
            logic [spira_pkg::M_TDATA_W-1:0] exp_word;
            if (expected_levels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %04h", word);
                return;
            end
            exp_word = pack_levels(expected_levels.pop_front());
            if (word !== exp_word) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %04h, actual %04h", exp_word, word);
            end
        endfunction
    endclass

    logic                            aclk          = 1'b0;
    logic                            aresetn       = 1'b0;
    logic                            cfg_we        = 1'b0;
    logic [6:0]                      cfg_wdata     = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [spira_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                            s_axis_tuser  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [spira_pkg::M_TDATA_W-1:0] m_axis_tdata;

    spi_scoreboard_t line_model;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_req       = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    spi_register_access_master uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always #1 aclk = ~aclk;

    // result side ready, with random stalls and a long hold-off on request
    always @(negedge aclk) begin
        if (hold_left == 0 && hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // result check and watchdog on accepted transactions
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready)
                line_model.check_levels(m_axis_tdata);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("spi_register_access_master_tb: FAIL");
                $finish;
            end
        end
    end

    function automatic spira_pkg::item_t make_item(logic kind, logic rnw, logic [7:0] reg_addr,
                                                   logic [7:0] wdata, logic sdi);
        spira_pkg::item_t it;
        it.kind           = kind;
        it.read_not_write = rnw;
        it.reg_address    = reg_addr;
        it.write_data     = wdata;
        it.serial_data_in = sdi;
        return it;
    endfunction

    // offer one input transaction, called and returning at a falling edge
    task automatic send_item(spira_pkg::item_t it);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= {6'b0, it.serial_data_in, it.write_data, it.reg_address,
                          it.read_not_write};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        line_model.note_item(it);
        @(negedge aclk);
    endtask

    // tick with random content in the fields a tick does not use
    task automatic send_tick(logic sdi);
        send_item(make_item(spira_pkg::KIND_TICK, 1'($urandom), 8'($urandom), 8'($urandom),
                            sdi));
    endtask

    task automatic send_random_start();
        send_item(make_item(spira_pkg::KIND_START, 1'($urandom), 8'($urandom), 8'($urandom),
                            1'($urandom)));
    endtask

    // one whole frame; sdi_level below zero means random device data
    task automatic run_frame(logic rnw, logic [7:0] reg_addr, logic [7:0] wdata,
                             int sdi_level);
        logic sdi;
        send_item(make_item(spira_pkg::KIND_START, rnw, reg_addr, wdata, 1'($urandom)));
        while (line_model.active) begin
            if ($urandom_range(99) < BUSY_START_PCT)
                send_random_start();
            sdi = (sdi_level < 0) ? 1'($urandom) : 1'(sdi_level);
            send_tick(sdi);
        end
        // up to two ticks while idle
        repeat ($urandom_range(2)) send_tick(1'($urandom));
    endtask

    // drain all results, then write the device address
    task automatic write_chip_address(logic [6:0] addr);
        s_axis_tvalid <= 1'b0;
        while (line_model.expected_levels.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= addr;
        @(negedge aclk);
        cfg_we <= 1'b0;
        line_model.chip_addr = addr;
    endtask

    // stimulus
    initial begin
        line_model = new();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: idle ticks, write at reset address with a start while busy
        send_tick(1'b1);
        send_item(make_item(spira_pkg::KIND_TICK, 1'b1, 8'hFF, 8'hFF, 1'b0));
        send_item(make_item(spira_pkg::KIND_START, 1'b0, 8'h00, 8'hFF, 1'b0));
        send_item(make_item(spira_pkg::KIND_START, 1'b1, 8'hFF, 8'hFF, 1'b1));
        while (line_model.active) send_tick(1'($urandom));
        send_tick(1'b0);

        // one frame in each idling phase
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_chip_address(7'($urandom));
                1: write_chip_address(7'h7F);
                2: write_chip_address(7'h00);
                default: write_chip_address(7'($urandom));
            endcase
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 58; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 58; end
                default: begin src_idle_pct = 20; sink_stall_pct = 20; end
            endcase
            // long hold-off on the result side so the input backs up
            if (ph == 0) hold_req = HOLD_CYCLES;
            case (ph)
                // highest address, read with the device driving ones
                1: run_frame(1'b1, 8'hFF, 8'hFF, 1);
                // lowest address, read of zeros
                2: run_frame(1'b1, 8'h5A, 8'hFF, 0);
                // write of zero
                3: run_frame(1'b0, 8'hA5, 8'h00, -1);
                default: run_frame(1'($urandom), 8'($urandom), 8'($urandom), -1);
            endcase
        end

        s_axis_tvalid <= 1'b0;
        while (line_model.expected_levels.size() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (line_model.mismatches == 0 && line_model.expected_levels.size() == 0)
            $display("spi_register_access_master_tb: PASS");
        else
            $display("spi_register_access_master_tb: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/spira_pkg.sv
rtl/core/spira_in_reg.sv
rtl/core/spira_seq.sv
rtl/core/spi_register_access_master.sv
rtl/core/spira_checker.sv
dv/spi_register_access_master_tb.sv
